// ----- hw/rtl/gn2d_pkg.sv -----
// Shared constants, types and helpers for the 2D gradient noise block.
// No dependencies; used by every module under hw/rtl except gn2d_queue.
`timescale 1ns / 1ps
`default_nettype none
package gn2d_pkg;
	localparam int DEF_ANGLE_BITS = 10;
	localparam int DEF_FRAC_BITS = 16;
	localparam int QDEPTH = 4;
	localparam int BACK_LAT = 13;

	localparam logic [31:0] HASH_A = 32'd3284157443;
	localparam logic [31:0] HASH_B = 32'd1911520717;
	localparam logic [31:0] HASH_C = 32'd2048419325;
	localparam logic [16:0] SIN_C1 = 17'd102944;
	localparam logic [15:0] SIN_C3 = 16'd42048;
	localparam logic [12:0] SIN_C5 = 13'd4640;
	localparam logic [15:0] QUARTER = 16'd16384;
	localparam logic [17:0] WEIGHT_3 = 18'd196608;

	typedef struct packed {
		logic f1;
		logic f2;
	} front_stat_t;

	function automatic logic [31:0] rot16(input logic [31:0] v);
		return {v[15:0], v[31:16]};
	endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/gradient_noise_2d.sv -----
// 2D gradient noise, top level: front end, queue and back end.
// Depends on gn2d_pkg, gn2d_front, gn2d_queue and gn2d_back.
//
// One point is taken per clock (start while busy is low) and each gives one noise
// value on noise_value, marked by a one-cycle done pulse, after two front-end stages
// (the first loaded at the edge that takes the point), the queue and a thirteen-stage
// back-end pipeline built around the three hash multipliers and the gradient
// polynomial. Results come out in input order. The receiver cannot hold results off,
// so the queue always drains and busy stays low in steady streaming.
`timescale 1ns / 1ps
`default_nettype none
module gradient_noise_2d #(
	parameter int ANGLE_BITS = gn2d_pkg::DEF_ANGLE_BITS,
	parameter int FRAC_BITS = gn2d_pkg::DEF_FRAC_BITS
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  wire signed [31:0]  x_coord,
	input  wire signed [31:0]  y_coord,
	output logic               done,
	output logic signed [15:0] noise_value
);
	localparam int EW = 64 + 2*FRAC_BITS + 32;
	localparam int CW = $clog2(gn2d_pkg::QDEPTH+1);

	gn2d_pkg::front_stat_t stat;
	logic push, pop;
	logic [EW-1:0] wentry, rentry;
	logic [CW-1:0] level;

	assign busy = (32'(level) + 32'(stat.f1) + 32'(stat.f2)) >= gn2d_pkg::QDEPTH;

	gn2d_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .accept(start && !busy),
		.x_coord(x_coord), .y_coord(y_coord),
		.stat(stat), .push(push), .entry(wentry)
	);

	gn2d_queue #(.WIDTH(EW), .DEPTH(gn2d_pkg::QDEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(wentry),
		.pop(pop), .rdata(rentry), .level(level)
	);

	gn2d_back #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .in_valid(pop), .in_entry(rentry),
		.done(done), .noise_value(noise_value)
	);
endmodule
`default_nettype wire

// ----- hw/rtl/gn2d_front.sv -----
// Front end: splits each point into cell index and fraction and forms smoothstep weights.
// Depends on gn2d_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gn2d_front #(
	parameter int FRAC_BITS = gn2d_pkg::DEF_FRAC_BITS
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       accept,
	input  wire signed [31:0]         x_coord,
	input  wire signed [31:0]         y_coord,
	output gn2d_pkg::front_stat_t     stat,
	output logic                      push,
	output logic [64+2*FRAC_BITS+31:0] entry
);
	localparam int FB = FRAC_BITS;

	logic        v_f1, v_f2;
	logic [31:0] x0_f1, y0_f1, x0_f2, y0_f2;
	logic [FB-1:0] fx_f1, fy_f1, fx_f2, fy_f2;
	logic [15:0] ux_f1, uy_f1, sx_f2, sy_f2;
	logic [31:0] uux_f1, uuy_f1;
	logic [15:0] ux, uy;
	logic [49:0] wx, wy;

	// The fraction rescaled to Q16, truncated when it carries more bits.
	assign ux = 16'({x_coord[FB-1:0], 16'h0} >> FB);
	assign uy = 16'({y_coord[FB-1:0], 16'h0} >> FB);
	assign wx = 50'(uux_f1) * 50'(gn2d_pkg::WEIGHT_3 - {1'b0, ux_f1, 1'b0});
	assign wy = 50'(uuy_f1) * 50'(gn2d_pkg::WEIGHT_3 - {1'b0, uy_f1, 1'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_f1 <= 1'b0;
			v_f2 <= 1'b0;
		end else begin
			v_f1 <= accept;
			v_f2 <= v_f1;
		end
	end

	always_ff @(posedge clk) begin
		x0_f1  <= 32'(x_coord >>> FB);
		y0_f1  <= 32'(y_coord >>> FB);
		fx_f1  <= x_coord[FB-1:0];
		fy_f1  <= y_coord[FB-1:0];
		ux_f1  <= ux;
		uy_f1  <= uy;
		uux_f1 <= 32'(ux) * 32'(ux);
		uuy_f1 <= 32'(uy) * 32'(uy);
		x0_f2  <= x0_f1;
		y0_f2  <= y0_f1;
		fx_f2  <= fx_f1;
		fy_f2  <= fy_f1;
		sx_f2  <= wx[47:32];
		sy_f2  <= wy[47:32];
	end

	assign stat.f1 = v_f1;
	assign stat.f2 = v_f2;
	assign push = v_f2;
	assign entry = {x0_f2, y0_f2, fx_f2, fy_f2, sx_f2, sy_f2};
endmodule
`default_nettype wire

// ----- hw/rtl/gn2d_queue.sv -----
// Short queue between the front end and the back end.
// Does not use gn2d_pkg itself; its parent sets DEPTH from gn2d_pkg::QDEPTH.
`timescale 1ns / 1ps
`default_nettype none
module gn2d_queue #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 4
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  wire  [WIDTH-1:0] wdata,
	output logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic [$clog2(DEPTH+1)-1:0] level
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;
	logic full;

	assign full = (count_q == CW'(DEPTH));
	// The back end never stalls, so the head drains whenever something is there.
	assign pop = (count_q != '0);
	assign rdata = slot_q[rd_q];
	assign level = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push && !full) wr_q <= AW'((32'(wr_q) + 1) % DEPTH);
			if (pop) rd_q <= AW'((32'(rd_q) + 1) % DEPTH);
			count_q <= count_q + CW'(push && !full) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) slot_q[wr_q] <= wdata;
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("queue written while full");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH)) else $error("queue count out of range");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (count_q == $past(count_q) - CW'(1)))
		else $error("queue did not drain");
`endif
endmodule
`default_nettype wire

// ----- hw/rtl/gn2d_back.sv -----
// Back end: corner hashing, gradient evaluation, dot products and the two-axis blend.
// Depends on gn2d_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gn2d_back #(
	parameter int ANGLE_BITS = gn2d_pkg::DEF_ANGLE_BITS,
	parameter int FRAC_BITS = gn2d_pkg::DEF_FRAC_BITS
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	input  wire [64+2*FRAC_BITS+31:0]  in_entry,
	output logic                       done,
	output logic signed [15:0]         noise_value
);
	localparam int AB = ANGLE_BITS;
	localparam int FB = FRAC_BITS;
	localparam int LAT = gn2d_pkg::BACK_LAT;
	localparam int PW = FB + 17;

	logic [31:0] ex0, ey0;
	logic [FB-1:0] efx, efy;
	logic [15:0] esx, esy;

	logic [LAT:1] v_q;
	logic [FB-1:0] fx_p_q [LAT];
	logic [FB-1:0] fy_p_q [LAT];
	logic [15:0]   sx_p_q [LAT];
	logic [15:0]   sy_p_q [LAT];

	logic [31:0] a_s1 [4], cy_s1 [4], a_s2 [4], b_s2 [4], h_s3 [4];
	logic [14:0] z_s4 [8], z2_s4 [8], z_s5 [8], z2_s5 [8], z_s6 [8];
	logic        neg_s4 [8], neg_s5 [8], neg_s6 [8];
	logic [15:0] t_s5 [8];
	logic [16:0] t2_s6 [8];
	logic signed [15:0] g_s7 [8];
	logic signed [PW-1:0] px_s8 [4], py_s8 [4];
	logic signed [17:0] n_s9 [4];
	logic signed [35:0] pt_s10, pb_s10;
	logic signed [17:0] n0_s10, n2_s10;
	logic signed [19:0] top_s11, bot_s11, top_s12, v_s13;
	logic signed [36:0] pv_s12;

	logic [15:0] ph_c [8];
	logic [14:0] z_c [8];
	logic [29:0] zz_c [8];
	logic [31:0] s_c [8];
	logic [15:0] sm_c [8];
	logic signed [PW:0] dot_c [4];

	assign {ex0, ey0, efx, efy, esx, esy} = in_entry;

	always_comb begin
		for (int j = 0; j < 8; j++) begin
			ph_c[j] = {h_s3[j/2][31 -: AB], {(16-AB){1'b0}}};
			if (j % 2 == 1) ph_c[j] = ph_c[j] + gn2d_pkg::QUARTER;
			// Odd quadrants mirror the quarter wave.
			z_c[j] = ph_c[j][14] ? 15'(gn2d_pkg::QUARTER - {2'b0, ph_c[j][13:0]})
			                     : {1'b0, ph_c[j][13:0]};
			zz_c[j] = 30'(z_c[j]) * 30'(z_c[j]);
			s_c[j] = 32'(z_s6[j]) * 32'(t2_s6[j]);
			sm_c[j] = (s_c[j][31:16] > gn2d_pkg::QUARTER) ? gn2d_pkg::QUARTER : s_c[j][31:16];
		end
		for (int k = 0; k < 4; k++)
			dot_c[k] = (PW+1)'(px_s8[k]) + (PW+1)'(py_s8[k]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[LAT-1:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		fx_p_q[0] <= efx;
		fy_p_q[0] <= efy;
		sx_p_q[0] <= esx;
		sy_p_q[0] <= esy;
		for (int i = 1; i < LAT; i++) begin
			fx_p_q[i] <= fx_p_q[i-1];
			fy_p_q[i] <= fy_p_q[i-1];
			sx_p_q[i] <= sx_p_q[i-1];
			sy_p_q[i] <= sy_p_q[i-1];
		end
		for (int k = 0; k < 4; k++) begin
			a_s1[k]  <= (k % 2 == 1 ? ex0 + 32'd1 : ex0) * gn2d_pkg::HASH_A;
			cy_s1[k] <= (k / 2 == 1) ? ey0 + 32'd1 : ey0;
			b_s2[k]  <= (cy_s1[k] ^ gn2d_pkg::rot16(a_s1[k])) * gn2d_pkg::HASH_B;
			a_s2[k]  <= a_s1[k];
			h_s3[k]  <= (a_s2[k] ^ gn2d_pkg::rot16(b_s2[k])) * gn2d_pkg::HASH_C;
		end
		for (int j = 0; j < 8; j++) begin
			z_s4[j]   <= z_c[j];
			z2_s4[j]  <= zz_c[j][28:14];
			neg_s4[j] <= ph_c[j][15];
			t_s5[j]   <= gn2d_pkg::SIN_C3 - 16'((28'(gn2d_pkg::SIN_C5) * 28'(z2_s4[j])) >> 14);
			z_s5[j]   <= z_s4[j];
			z2_s5[j]  <= z2_s4[j];
			neg_s5[j] <= neg_s4[j];
			t2_s6[j]  <= gn2d_pkg::SIN_C1 - 17'((31'(t_s5[j]) * 31'(z2_s5[j])) >> 14);
			z_s6[j]   <= z_s5[j];
			neg_s6[j] <= neg_s5[j];
			g_s7[j]   <= neg_s6[j] ? -$signed(sm_c[j]) : $signed(sm_c[j]);
		end
		// Corners at x0+1 or y0+1 see an offset of fraction minus one.
		for (int k = 0; k < 4; k++) begin
			px_s8[k] <= $signed({(k % 2 == 1), fx_p_q[6]}) * g_s7[2*k];
			py_s8[k] <= $signed({(k / 2 == 1), fy_p_q[6]}) * g_s7[2*k+1];
			n_s9[k]  <= dot_c[k][FB+17:FB];
		end
		pt_s10  <= 36'(19'(n_s9[1]) - 19'(n_s9[0])) * 36'($signed({1'b0, sx_p_q[8]}));
		pb_s10  <= 36'(19'(n_s9[3]) - 19'(n_s9[2])) * 36'($signed({1'b0, sx_p_q[8]}));
		n0_s10  <= n_s9[0];
		n2_s10  <= n_s9[2];
		top_s11 <= 20'(n0_s10) + 20'(pt_s10 >>> 16);
		bot_s11 <= 20'(n2_s10) + 20'(pb_s10 >>> 16);
		pv_s12  <= 37'(bot_s11 - top_s11) * 37'($signed({1'b0, sy_p_q[10]}));
		top_s12 <= top_s11;
		v_s13   <= top_s12 + 20'(pv_s12 >>> 16);
	end

	assign done = v_q[LAT];
	assign noise_value = (v_s13 > 20'sd32767) ? 16'sd32767 :
	                     (v_s13 < -20'sd32768) ? -16'sd32768 : v_s13[15:0];
endmodule
`default_nettype wire
